/* hw/rtl/tptc_pkg.sv */
// Shared types and constants for the timed pulse tilt controller.
package tptc_pkg;

   localparam int ANGLE_W   = 9;
   localparam int DB_W      = 11;
   localparam int MS_W      = 16;
   localparam int PHASE_W   = 2;
   localparam int NOW_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // phase codes
   localparam logic [PHASE_W-1:0] PHASE_DEADBAND = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_PULSE    = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_REST     = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_NEW      = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_REST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACTION     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY      = 3'd5;

   // reset values
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN_RST  = -9'sd10;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX_RST  = 9'sd10;
   localparam logic signed [ANGLE_W-1:0] ANGLE_REST_RST = 9'sd0;
   localparam logic [DB_W-1:0]           DEADBAND_RST   = 11'd10;
   localparam logic [MS_W-1:0]           ACTION_RST     = 16'd100;
   localparam logic [MS_W-1:0]           DELAY_RST      = 16'd500;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle_min;
      logic signed [ANGLE_W-1:0] angle_max;
      logic signed [ANGLE_W-1:0] angle_rest;
      logic [DB_W-1:0]           deadband_px;
      logic [MS_W-1:0]           action_ms;
      logic [MS_W-1:0]           delay_ms;
   } cfg_type;

endpackage

/* hw/rtl/tptc_regs.sv */
// Configuration register file of the tilt controller.
module tptc_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tptc_pkg::CSR_DAT_W-1:0]   csr_data,
   output tptc_pkg::cfg_type                cfg
);

   tptc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tptc_pkg::REG_ANGLE_MIN:  cfg_in.angle_min  = csr_data[tptc_pkg::ANGLE_W-1:0];
            tptc_pkg::REG_ANGLE_MAX:  cfg_in.angle_max  = csr_data[tptc_pkg::ANGLE_W-1:0];
            tptc_pkg::REG_ANGLE_REST: cfg_in.angle_rest = csr_data[tptc_pkg::ANGLE_W-1:0];
            tptc_pkg::REG_DEADBAND:   cfg_in.deadband_px = csr_data[tptc_pkg::DB_W-1:0];
            tptc_pkg::REG_ACTION:     cfg_in.action_ms  = csr_data[tptc_pkg::MS_W-1:0];
            tptc_pkg::REG_DELAY:      cfg_in.delay_ms   = csr_data[tptc_pkg::MS_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_min   <= tptc_pkg::ANGLE_MIN_RST;
         cfg_ff.angle_max   <= tptc_pkg::ANGLE_MAX_RST;
         cfg_ff.angle_rest  <= tptc_pkg::ANGLE_REST_RST;
         cfg_ff.deadband_px <= tptc_pkg::DEADBAND_RST;
         cfg_ff.action_ms   <= tptc_pkg::ACTION_RST;
         cfg_ff.delay_ms    <= tptc_pkg::DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/tptc_calc.sv */
// Combinational step: deadband test, pulse timing, angle pick and clamp.
module tptc_calc #(
   parameter int POS_BITS  = 11,
   parameter int TIME_BITS = 32
) (
   input  tptc_pkg::cfg_type                   cfg,
   input  logic [POS_BITS-1:0]                 desired_pos,
   input  logic [POS_BITS-1:0]                 current_pos,
   input  logic [tptc_pkg::NOW_W-1:0]          now_ms,
   input  logic [TIME_BITS-1:0]                pulse_start,
   output logic signed [tptc_pkg::ANGLE_W-1:0] tilt_deg,
   output logic [tptc_pkg::PHASE_W-1:0]        phase,
   output logic                                new_pulse,
   output logic [TIME_BITS-1:0]                now_time
);

   localparam int MW = (POS_BITS > tptc_pkg::DB_W + 1) ? POS_BITS : tptc_pkg::DB_W + 1;
   localparam int TW = (TIME_BITS > tptc_pkg::MS_W + 1) ? TIME_BITS : tptc_pkg::MS_W + 1;
   localparam int AW = tptc_pkg::ANGLE_W + 1;

   logic signed [POS_BITS:0]   err;
   logic [POS_BITS-1:0]        mag;
   logic [MW-1:0]              mag_w, db_w, db2_w;
   logic                       in_db, near, err_pos;
   logic [TIME_BITS-1:0]       elapsed;
   logic [tptc_pkg::MS_W:0]    cycle_len;
   logic [TW-1:0]              elapsed_w, act_w, cycle_w;
   logic signed [AW-1:0]       min_w, max_w, rest_w, pick, angle, clamped;

   assign err     = $signed({1'b0, desired_pos}) - $signed({1'b0, current_pos});
   assign mag     = err[POS_BITS] ? POS_BITS'(-err) : err[POS_BITS-1:0];
   assign err_pos = !err[POS_BITS] && (err != '0);
   assign mag_w   = MW'(mag);
   assign db_w    = MW'(cfg.deadband_px);
   assign db2_w   = MW'({cfg.deadband_px, 1'b0});
   assign in_db   = mag_w <= db_w;
   assign near    = mag_w <= db2_w;

   // elapsed time wraps at the timer width
   assign now_time  = TIME_BITS'(now_ms);
   assign elapsed   = now_time - pulse_start;
   assign cycle_len = {1'b0, cfg.action_ms} + {1'b0, cfg.delay_ms};
   assign elapsed_w = TW'(elapsed);
   assign act_w     = TW'(cfg.action_ms);
   assign cycle_w   = TW'(cycle_len);

   assign min_w  = AW'(cfg.angle_min);
   assign max_w  = AW'(cfg.angle_max);
   assign rest_w = AW'(cfg.angle_rest);

   always_comb begin
      if (err_pos) begin
         pick = near ? min_w + AW'(1) : min_w;
      end else begin
         pick = near ? max_w - AW'(1) : max_w;
      end
   end

   always_comb begin
      new_pulse = 1'b0;
      priority if (in_db) begin
         angle = rest_w;
         phase = tptc_pkg::PHASE_DEADBAND;
      end else if (elapsed_w <= act_w) begin
         angle = pick;
         phase = tptc_pkg::PHASE_PULSE;
      end else if (elapsed_w <= cycle_w) begin
         angle = rest_w;
         phase = tptc_pkg::PHASE_REST;
      end else begin
         angle     = pick;
         phase     = tptc_pkg::PHASE_NEW;
         new_pulse = 1'b1;
      end
   end

   // lower limit first, upper limit wins when limits are inverted
   always_comb begin
      clamped = angle;
      if (clamped < min_w) clamped = min_w;
      if (clamped > max_w) clamped = max_w;
   end

   assign tilt_deg = clamped[tptc_pkg::ANGLE_W-1:0];

endmodule

/* hw/rtl/timed_pulse_tilt_controller_core.sv */
// Top level of the timed pulse tilt controller: pipeline registers and pulse timer.
//
//   channel  direction  handshake            content
//   req      in         req_tvalid/tready    desired_pos, current_pos, now_ms
//   rsp      out        rsp_tvalid/tready    tilt_deg, phase
//   csr      in         csr_valid/ready      register index and write data
//
// Each word waits in the input register and then moves to the result register; one
// word per cycle is sustained while rsp is ready. The pulse start time updates as a
// word that starts a new pulse moves to the result register, so the next word sees
// it. Reset clears both valid flags and the start time and loads the register reset values.
// A stalled rsp holds the result; req can still fill an empty input register behind it.
module timed_pulse_tilt_controller_core #(
   parameter int POS_BITS  = 11,
   parameter int TIME_BITS = 32,
   localparam int REQ_BITS = 2 * POS_BITS + tptc_pkg::NOW_W,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = tptc_pkg::ANGLE_W + tptc_pkg::PHASE_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // desired_pos, current_pos, now_ms (low bit up), zero filled
   input  logic [REQ_W-1:0]                 req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tilt_deg, phase (low bit up), zero filled
   output logic [RSP_W-1:0]                 rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tptc_pkg::CSR_DAT_W-1:0]   csr_data
);

   tptc_pkg::cfg_type cfg;

   logic                                s1_valid_ff, s1_valid_in;
   logic [POS_BITS-1:0]                 des_ff, cur_ff;
   logic [tptc_pkg::NOW_W-1:0]          now_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [tptc_pkg::ANGLE_W-1:0] tilt_ff, tilt_calc;
   logic [tptc_pkg::PHASE_W-1:0]        phase_ff, phase_calc;
   logic [TIME_BITS-1:0]                start_ff, start_in, now_time;
   logic                                new_pulse, advance, req_take;

   tptc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tptc_calc #(
      .POS_BITS  (POS_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_calc (
      .cfg         (cfg),
      .desired_pos (des_ff),
      .current_pos (cur_ff),
      .now_ms      (now_ff),
      .pulse_start (start_ff),
      .tilt_deg    (tilt_calc),
      .phase       (phase_calc),
      .new_pulse   (new_pulse),
      .now_time    (now_time)
   );

   // move the held word on when the result register is free or being drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign start_in     = (advance && new_pulse) ? now_time : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         des_ff <= req_tdata[POS_BITS-1:0];
         cur_ff <= req_tdata[2*POS_BITS-1:POS_BITS];
         now_ff <= req_tdata[REQ_BITS-1:2*POS_BITS];
      end
      if (advance) begin
         tilt_ff  <= tilt_calc;
         phase_ff <= phase_calc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({phase_ff, tilt_ff});

endmodule

/* sim/tb.sv */
// Self-checking testbench for the timed pulse tilt controller core.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_BITS   = 56;
   localparam int RSP_BITS   = 16;
   localparam int POS_MAX    = 2047;
   localparam int STALL_MAX  = 2000;
   localparam int SEG_WORDS  = 45;
   localparam int SEGMENTS   = 4;

   typedef struct packed {
      logic [tptc_pkg::PHASE_W-1:0]        phase;
      logic signed [tptc_pkg::ANGLE_W-1:0] tilt;
   } tilt_cmd_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [REQ_BITS-1:0]              req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]              rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tptc_pkg::CSR_IDX_W-1:0]   csr_index = tptc_pkg::REG_ANGLE_MIN;
   logic [tptc_pkg::CSR_DAT_W-1:0]   csr_data = '0;

   tptc_pkg::cfg_type ctl;
   logic [31:0]       last_pulse_ms;
   tilt_cmd_type      expected_cmds[$];
   int                mismatch_count = 0;
   int                rsp_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_idle_pct = 0;
   int                quiet_cycles = 0;

   timed_pulse_tilt_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // angle for an active pulse, one degree inward when the error is near
   function automatic int tilt_toward(input int err, input bit near);
      int lo, hi;
      lo = $signed(ctl.angle_min);
      hi = $signed(ctl.angle_max);
      if (err > 0)
         return near ? lo + 1 : lo;
      return near ? hi - 1 : hi;
   endfunction

   function automatic tilt_cmd_type predict_tilt(input logic [10:0] des,
                                                 input logic [10:0] cur,
                                                 input logic [31:0] now);
      int           err, mag, angle, lo, hi;
      bit           near;
      logic [31:0]  elapsed;
      logic [16:0]  window;
      tilt_cmd_type cmd;
      lo = $signed(ctl.angle_min);
      hi = $signed(ctl.angle_max);
      err = int'(des) - int'(cur);
      mag = (err < 0) ? -err : err;
      near = (mag <= 2 * int'(ctl.deadband_px));
      elapsed = now - last_pulse_ms;
      window = {1'b0, ctl.action_ms} + {1'b0, ctl.delay_ms};
      if (mag <= int'(ctl.deadband_px)) begin
         angle = $signed(ctl.angle_rest);
         cmd.phase = tptc_pkg::PHASE_DEADBAND;
      end else if (elapsed <= ctl.action_ms) begin
         angle = tilt_toward(err, near);
         cmd.phase = tptc_pkg::PHASE_PULSE;
      end else if (elapsed <= window) begin
         angle = $signed(ctl.angle_rest);
         cmd.phase = tptc_pkg::PHASE_REST;
      end else begin
         angle = tilt_toward(err, near);
         last_pulse_ms = now;
         cmd.phase = tptc_pkg::PHASE_NEW;
      end
      // lower limit first, so inverted limits end at the upper one
      if (angle < lo) angle = lo;
      if (angle > hi) angle = hi;
      cmd.tilt = angle[8:0];
      return cmd;
   endfunction

   // starts and returns at a falling edge; valid stays high for the next word
   task automatic send_sample(input logic [10:0] des, input logic [10:0] cur,
                              input logic [31:0] now);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, now, cur, des};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_cmds.push_back(predict_tilt(des, cur, now));
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [tptc_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tptc_pkg::REG_ANGLE_MIN:  ctl.angle_min = value[8:0];
         tptc_pkg::REG_ANGLE_MAX:  ctl.angle_max = value[8:0];
         tptc_pkg::REG_ANGLE_REST: ctl.angle_rest = value[8:0];
         tptc_pkg::REG_DEADBAND:   ctl.deadband_px = value[10:0];
         tptc_pkg::REG_ACTION:     ctl.action_ms = value[15:0];
         tptc_pkg::REG_DELAY:      ctl.delay_ms = value[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input int amin, input int amax, input int arest,
                             input int db, input int act, input int dly);
      write_reg(tptc_pkg::REG_ANGLE_MIN, amin);
      write_reg(tptc_pkg::REG_ANGLE_MAX, amax);
      write_reg(tptc_pkg::REG_ANGLE_REST, arest);
      write_reg(tptc_pkg::REG_DEADBAND, db);
      write_reg(tptc_pkg::REG_ACTION, act);
      write_reg(tptc_pkg::REG_DELAY, dly);
      csr_valid <= 1'b0;
   endtask

   // drop valid and wait until every expected word has come back
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_first_pulse_cycle();
      send_sample(11'd100, 11'd100, 32'd0);
      send_sample(11'd2047, 11'd0, 32'd0);
      send_sample(11'd0, 11'd2047, 32'd100);
      send_sample(11'd0, 11'd15, 32'd101);
      send_sample(11'd15, 11'd0, 32'd600);
      send_sample(11'd15, 11'd0, 32'd601);
      send_sample(11'd0, 11'd20, 32'd651);
      send_sample(11'd10, 11'd0, 32'd652);
      send_sample(11'd0, 11'd11, 32'd653);
   endtask

   task automatic test_timestamp_wrap();
      send_sample(11'd500, 11'd0, 32'hFFFF_FFF0);
      send_sample(11'd0, 11'd500, 32'h0000_0050);
      send_sample(11'd0, 11'd500, 32'h0000_0300);
   endtask

   task automatic test_inverted_limits();
      drain_pipeline();
      set_config(180, -180, -180, 10, 100, 500);
      send_sample(11'd5, 11'd0, last_pulse_ms);
      send_sample(11'd0, 11'd2047, last_pulse_ms + 32'd700);
   endtask

   task automatic test_zero_windows();
      drain_pipeline();
      set_config(-180, 180, 180, 0, 0, 0);
      send_sample(11'd2047, 11'd2047, last_pulse_ms);
      send_sample(11'd1, 11'd0, last_pulse_ms);
      send_sample(11'd1, 11'd0, last_pulse_ms + 32'd1);
      send_sample(11'd0, 11'd1, last_pulse_ms);
   endtask

   task automatic test_wide_windows();
      drain_pipeline();
      set_config(-180, 180, 0, 1023, 65535, 65535);
      send_sample(11'd2047, 11'd0, last_pulse_ms + 32'd131070);
      send_sample(11'd2047, 11'd0, last_pulse_ms + 32'd131071);
      send_sample(11'd0, 11'd1024, last_pulse_ms + 32'd65535);
      send_sample(11'd1023, 11'd0, last_pulse_ms);
   endtask

   function automatic int pick_window();
      if ($urandom_range(4) == 0)
         return $urandom_range(1) ? 0 : 65535;
      return $urandom_range(1, 250);
   endfunction

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int          act, dly, db, off, cur_pos, des_pos, roll;
      logic [31:0] span, now;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_pipeline();
         act = pick_window();
         dly = pick_window();
         db = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 0 : POS_MAX)
                                       : $urandom_range(1, 80);
         set_config(int'($urandom_range(360)) - 180, int'($urandom_range(360)) - 180,
                    int'($urandom_range(360)) - 180, db, act, dly);
         span = act + dly;
         now = last_pulse_ms + $urandom_range(0, span);
         for (int n = 0; n < SEG_WORDS; n++) begin
            roll = $urandom_range(99);
            if (roll < 4)
               now = $urandom();
            else if (roll < 6)
               now = 32'hFFFF_FFFF - $urandom_range(0, span);
            else if (roll < 16) begin
               // land right on a window edge
               case ($urandom_range(3))
                  0: now = last_pulse_ms + act;
                  1: now = last_pulse_ms + act + 1;
                  2: now = last_pulse_ms + span;
                  default: now = last_pulse_ms + span + 1;
               endcase
            end else
               now = now + $urandom_range(0, span / 3 + 2);
            des_pos = $urandom_range(POS_MAX);
            if ($urandom_range(9) == 0)
               cur_pos = $urandom_range(POS_MAX);
            else begin
               off = $urandom_range(0, 3 * db + 2);
               cur_pos = $urandom_range(1) ? des_pos + off : des_pos - off;
               if (cur_pos < 0) cur_pos = 0;
               if (cur_pos > POS_MAX) cur_pos = POS_MAX;
            end
            send_sample(des_pos[10:0], cur_pos[10:0], now);
         end
      end
   endtask

   // receiver back-pressure, with the odd stretch of steady ready
   always @(negedge clock) begin
      if (quiet_cycles > 0) begin
         quiet_cycles <= quiet_cycles - 1;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(99) == 0) begin
         quiet_cycles <= $urandom_range(10, 40);
         rsp_tready <= 1'b1;
      end else
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      tilt_cmd_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tilt = rsp_tdata[8:0];
         got.phase = rsp_tdata[10:9];
         if (expected_cmds.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("word %0d: result with nothing expected (tilt %0d phase %0d)",
                        rsp_count, got.tilt, got.phase);
         end else begin
            want = expected_cmds.pop_front();
            if (want.tilt !== got.tilt || want.phase !== got.phase) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("word %0d: tilt exp %0d got %0d, phase exp %0d got %0d",
                           rsp_count, want.tilt, got.tilt, want.phase, got.phase);
            end
         end
         rsp_count <= rsp_count + 1;
      end
   end

   // watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      int stall_cycles;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      ctl.angle_min = tptc_pkg::ANGLE_MIN_RST;
      ctl.angle_max = tptc_pkg::ANGLE_MAX_RST;
      ctl.angle_rest = tptc_pkg::ANGLE_REST_RST;
      ctl.deadband_px = tptc_pkg::DEADBAND_RST;
      ctl.action_ms = tptc_pkg::ACTION_RST;
      ctl.delay_ms = tptc_pkg::DELAY_RST;
      last_pulse_ms = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_pulse_cycle();
      test_timestamp_wrap();
      test_inverted_limits();
      test_zero_windows();
      test_wide_windows();
      test_random_traffic(23, 61);
      test_random_traffic(61, 23);
      test_random_traffic(0, 0);
      drain_pipeline();

      if (mismatch_count == 0 && expected_cmds.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
